>>> rtl/core/hufd_pkg.sv
// Shared types and constants for the tree-walk decoder.
// Used by hufd_node_ram, hufd_walk and huffman_tree_walk_decoder; no dependencies.
package hufd_pkg;

	localparam int unsigned IDX_W = 9;
	localparam int unsigned SYM_W = 8;
	localparam int unsigned CNT_W = 32;

	localparam logic [IDX_W-1:0] NO_CHILD = 9'd511;

	localparam logic [1:0] KIND_NODE    = 2'd0;
	localparam logic [1:0] KIND_DATA    = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	localparam logic [1:0] CFG_TOTAL = 2'd0;
	localparam logic [1:0] CFG_ROOT  = 2'd1;

	typedef struct packed {
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic             leaf;
		logic [SYM_W-1:0] sym;
	} node_t;

	typedef struct packed {
		logic             valid;
		logic [SYM_W-1:0] sym;
		logic             bad;
		logic             last;
	} hufd_res_t;

	function automatic logic node_ok(input logic [IDX_W-1:0] idx, input logic [IDX_W:0] limit);
		node_ok = (idx != NO_CHILD) && ({1'b0, idx} < limit);
	endfunction

endpackage

>>> rtl/core/huffman_tree_walk_decoder.sv
// Huffman tree-walk decoder top level: configuration registers, node write
// decode, node table and walk sequencer.
// Depends on hufd_pkg, hufd_node_ram and hufd_walk.
//
// Command channel: a word is taken at a clock edge with start high and busy
// low. Node writes (kind 0) and restarts (kind 2) complete in that cycle and
// leave busy low; kind 3 is dropped. A data byte (kind 1) raises busy.
// The single read port of the node table sets the pace: the walk first reads
// the current node, then for each bit reads the child and checks it; after a
// leaf or a missing child the root is read again, the final bit skips that
// re-read, and a flush state gives out the last result. A byte holds busy
// until that flush, which comes early once the symbol count is reached.
// Results appear on symbol, bad_path and last for one cycle with
// result_valid high; the receiver cannot stall them. Results of a byte come
// out one behind the walk; the final one, with last set, is given in the
// first cycle with busy low again.
// Configuration: cfg_ready is always high; index 0 is total_symbols, index 1
// is root_node, other indices are dropped. Write only while idle.
// Reset clears the walk position, count and registers; node table contents
// are undefined until written.
module huffman_tree_walk_decoder #(
	parameter int MAX_NODES = 512
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         kind,
	input  logic [hufd_pkg::IDX_W-1:0]         node_index,
	input  logic [hufd_pkg::IDX_W-1:0]         left_child,
	input  logic [hufd_pkg::IDX_W-1:0]         right_child,
	input  logic                               is_leaf,
	input  logic [hufd_pkg::SYM_W-1:0]         leaf_symbol,
	input  logic [hufd_pkg::SYM_W-1:0]         data_byte,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [1:0]                         cfg_index,
	input  logic [hufd_pkg::CNT_W-1:0]         cfg_data,
	output logic                               result_valid,
	output logic [hufd_pkg::SYM_W-1:0]         symbol,
	output logic                               bad_path,
	output logic                               last
);
	import hufd_pkg::*;

	localparam int AW = $clog2(MAX_NODES);
	localparam logic [IDX_W:0] LIMIT = (IDX_W+1)'(MAX_NODES);

	logic [CNT_W-1:0] total_q;
	logic [IDX_W-1:0] root_q;
	logic             accept;
	logic             wr_en;
	node_t            wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	node_t            rd_data;
	hufd_res_t        res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			root_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TOTAL: total_q <= cfg_data;
				CFG_ROOT:  root_q  <= cfg_data[IDX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign accept  = start && !busy;
	assign wr_en   = accept && (kind == KIND_NODE) && node_ok(node_index, LIMIT);
	assign wr_data = '{left: left_child, right: right_child, leaf: is_leaf, sym: leaf_symbol};

	hufd_node_ram #(
		.DEPTH(MAX_NODES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (node_index[AW-1:0]),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	hufd_walk #(
		.MAX_NODES(MAX_NODES)
	) u_walk (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.kind          (kind),
		.data_byte     (data_byte),
		.total_symbols (total_q),
		.root_node     (root_q),
		.busy          (busy),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.res           (res)
	);

	assign result_valid = res.valid;
	assign symbol       = res.sym;
	assign bad_path     = res.bad;
	assign last         = res.last;

endmodule

>>> rtl/core/hufd_node_ram.sv
// Node table: one write port, one read port with registered read data.
// Depends on hufd_pkg for the node entry type.
module hufd_node_ram #(
	parameter int DEPTH = 512
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(DEPTH)-1:0]     waddr,
	input  hufd_pkg::node_t              wdata,
	input  logic                         re,
	input  logic [$clog2(DEPTH)-1:0]     raddr,
	output hufd_pkg::node_t              rdata
);
	import hufd_pkg::*;

	node_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/hufd_walk.sv
// Walk sequencer: follows one data bit per step through the node table
// and buffers results so the final word of a byte carries last.
// Depends on hufd_pkg; drives the read port of hufd_node_ram.
module hufd_walk #(
	parameter int MAX_NODES = 512
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  logic [1:0]                         kind,
	input  logic [hufd_pkg::SYM_W-1:0]         data_byte,
	input  logic [hufd_pkg::CNT_W-1:0]         total_symbols,
	input  logic [hufd_pkg::IDX_W-1:0]         root_node,
	output logic                               busy,
	output logic                               rd_en,
	output logic [$clog2(MAX_NODES)-1:0]       rd_addr,
	input  hufd_pkg::node_t                    rd_data,
	output hufd_pkg::hufd_res_t                res
);
	import hufd_pkg::*;

	localparam int AW = $clog2(MAX_NODES);
	localparam logic [IDX_W:0] LIMIT = (IDX_W+1)'(MAX_NODES);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RDCUR,
		S_CHILD,
		S_LEAF,
		S_FLUSH
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] cur_q;
	logic [CNT_W-1:0] count_q;
	logic [SYM_W-1:0] byte_q;
	logic [2:0]       bit_q;
	logic             pend_valid_q;
	logic [SYM_W-1:0] pend_sym_q;
	logic             pend_bad_q;
	hufd_res_t        res_q;

	logic             cur_ok;
	logic [IDX_W-1:0] next_idx;
	logic             next_ok;
	logic             cnt_done;
	logic             push;
	logic [SYM_W-1:0] push_sym;
	logic             push_bad;
	logic             step;

	always_comb begin
		cur_ok   = node_ok(cur_q, LIMIT);
		next_idx = byte_q[SYM_W-1] ? rd_data.right : rd_data.left;
		next_ok  = node_ok(next_idx, LIMIT);
		cnt_done = count_q >= total_symbols;
		rd_en    = 1'b0;
		rd_addr  = cur_q[AW-1:0];
		push     = 1'b0;
		push_sym = '0;
		push_bad = 1'b0;
		step     = 1'b0;
		case (state_q)
			S_RDCUR: begin
				rd_en = cur_ok;
			end
			S_CHILD: begin
				rd_addr = next_idx[AW-1:0];
				if (!cnt_done) begin
					if (!cur_ok || !next_ok) begin
						push     = 1'b1;
						push_bad = 1'b1;
						step     = 1'b1;
					end else begin
						rd_en = 1'b1;
					end
				end
			end
			S_LEAF: begin
				step = 1'b1;
				if (rd_data.leaf) begin
					push     = 1'b1;
					push_sym = rd_data.sym;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cur_q        <= '0;
			count_q      <= '0;
			byte_q       <= '0;
			bit_q        <= '0;
			pend_valid_q <= 1'b0;
			pend_sym_q   <= '0;
			pend_bad_q   <= 1'b0;
			res_q        <= '0;
		end else begin
			if (push && pend_valid_q) begin
				res_q <= '{valid: 1'b1, sym: pend_sym_q, bad: pend_bad_q, last: 1'b0};
			end else if ((state_q == S_FLUSH) && pend_valid_q) begin
				res_q <= '{valid: 1'b1, sym: pend_sym_q, bad: pend_bad_q, last: 1'b1};
			end else begin
				res_q.valid <= 1'b0;
			end
			if (push) begin
				pend_valid_q <= 1'b1;
				pend_sym_q   <= push_sym;
				pend_bad_q   <= push_bad;
			end
			if (step) begin
				byte_q <= {byte_q[SYM_W-2:0], 1'b0};
				bit_q  <= bit_q - 3'd1;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (kind)
							KIND_DATA: begin
								byte_q  <= data_byte;
								bit_q   <= 3'd7;
								state_q <= S_RDCUR;
							end
							KIND_RESTART: begin
								cur_q   <= root_node;
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				S_RDCUR: begin
					state_q <= S_CHILD;
				end
				S_CHILD: begin
					if (cnt_done) begin
						state_q <= S_FLUSH;
					end else if (push_bad) begin
						cur_q   <= root_node;
						state_q <= (bit_q == 3'd0) ? S_FLUSH : S_RDCUR;
					end else begin
						cur_q   <= next_idx;
						state_q <= S_LEAF;
					end
				end
				S_LEAF: begin
					if (rd_data.leaf) begin
						cur_q   <= root_node;
						count_q <= count_q + CNT_W'(1);
						state_q <= (bit_q == 3'd0) ? S_FLUSH : S_RDCUR;
					end else begin
						state_q <= (bit_q == 3'd0) ? S_FLUSH : S_CHILD;
					end
				end
				S_FLUSH: begin
					pend_valid_q <= 1'b0;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign res  = res_q;

endmodule

>>> bench/tb_top.sv
// Self-checking bench for huffman_tree_walk_decoder: builds random code trees, walks them
// with data bytes and checks every symbol word against an in-bench prediction of the walk.
// Depends on hufd_pkg and the huffman_tree_walk_decoder RTL only.
module tb_top;
	import hufd_pkg::*;

	localparam logic [1:0] KIND_SPARE    = 2'd3;
	localparam logic [1:0] CFG_SPARE     = 2'd3;
	localparam int         SETTLE_CYCLES = 30;
	localparam int         TARGET_WORDS  = 300;

	class decode_scoreboard;
		node_t            nodes [512];
		logic [IDX_W-1:0] walk_pos;
		logic [IDX_W-1:0] root_reg;
		logic [CNT_W-1:0] decoded;
		logic [CNT_W-1:0] total_reg;
		hufd_res_t        expected_syms [$];
		int               mismatches;

		function new();
			walk_pos   = '0;
			root_reg   = '0;
			decoded    = '0;
			total_reg  = '0;
			mismatches = 0;
		endfunction

		function bit present(logic [IDX_W-1:0] idx);
			return idx != NO_CHILD;
		endfunction

		function void note_reg(logic [1:0] idx, logic [CNT_W-1:0] val);
			case (idx)
				CFG_TOTAL: total_reg = val;
				CFG_ROOT:  root_reg = val[IDX_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_word(logic [1:0] k, logic [IDX_W-1:0] idx, logic [IDX_W-1:0] l,
				logic [IDX_W-1:0] r, logic lf, logic [SYM_W-1:0] s, logic [SYM_W-1:0] d);
			hufd_res_t        res;
			logic [IDX_W-1:0] child;
			int               made;
			made = 0;
			case (k)
				KIND_NODE: begin
					if (present(idx))
						nodes[idx] = '{left: l, right: r, leaf: lf, sym: s};
				end
				KIND_RESTART: begin
					walk_pos = root_reg;
					decoded  = '0;
				end
				KIND_DATA: begin
					for (int b = $bits(d) - 1; b >= 0; b--) begin
						if (decoded >= total_reg)
							break;
						if (!present(walk_pos))
							child = NO_CHILD;
						else
							child = d[b] ? nodes[walk_pos].right : nodes[walk_pos].left;
						if (!present(child) || nodes[child].leaf) begin
							res       = '0;
							res.valid = 1'b1;
							if (present(child)) begin
								res.sym = nodes[child].sym;
								decoded++;
							end else begin
								res.bad = 1'b1;
							end
							expected_syms.push_back(res);
							made++;
							walk_pos = root_reg;
						end else begin
							walk_pos = child;
						end
					end
					if (made > 0)
						expected_syms[expected_syms.size() - 1].last = 1'b1;
				end
				default: ;
			endcase
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch at %0t: %s", $time, msg);
		endfunction

		function void check_result(logic [SYM_W-1:0] s, logic bad, logic lst);
			hufd_res_t want;
			if (expected_syms.size() == 0) begin
				flag($sformatf("unexpected word symbol %02h bad_path %0b last %0b", s, bad, lst));
				return;
			end
			want = expected_syms.pop_front();
			if (want.sym !== s || want.bad !== bad || want.last !== lst)
				flag($sformatf("expected symbol %02h bad_path %0b last %0b, got %02h %0b %0b",
					want.sym, want.bad, want.last, s, bad, lst));
		endfunction
	endclass

	logic             clk         = 1'b0;
	logic             arst_n      = 1'b0;
	logic             start       = 1'b0;
	logic [1:0]       kind        = KIND_NODE;
	logic [IDX_W-1:0] node_index  = '0;
	logic [IDX_W-1:0] left_child  = '0;
	logic [IDX_W-1:0] right_child = '0;
	logic             is_leaf     = 1'b0;
	logic [SYM_W-1:0] leaf_symbol = '0;
	logic [SYM_W-1:0] data_byte   = '0;
	logic             cfg_valid   = 1'b0;
	logic [1:0]       cfg_index   = CFG_TOTAL;
	logic [CNT_W-1:0] cfg_data    = '0;
	logic             busy;
	logic             cfg_ready;
	logic             result_valid;
	logic [SYM_W-1:0] symbol;
	logic             bad_path;
	logic             last;

	decode_scoreboard sb;
	bit               calm;
	int               words_done;
	bit               filled [512];
	int               filled_q [$];
	bit               in_tree [512];

	huffman_tree_walk_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.node_index   (node_index),
		.left_child   (left_child),
		.right_child  (right_child),
		.is_leaf      (is_leaf),
		.leaf_symbol  (leaf_symbol),
		.data_byte    (data_byte),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.symbol       (symbol),
		.bad_path     (bad_path),
		.last         (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(negedge clk) begin
		if (arst_n && result_valid)
			sb.check_result(symbol, bad_path, last);
	end

	task automatic send_word(logic [1:0] k, logic [IDX_W-1:0] idx, logic [IDX_W-1:0] l,
			logic [IDX_W-1:0] r, logic lf, logic [SYM_W-1:0] s, logic [SYM_W-1:0] d);
		int gap;
		gap = 0;
		if (!calm)
			while ($urandom_range(0, 99) < 25)
				gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		kind        <= k;
		node_index  <= idx;
		left_child  <= l;
		right_child <= r;
		is_leaf     <= lf;
		leaf_symbol <= s;
		data_byte   <= d;
		do @(negedge clk); while (busy);
		sb.note_word(k, idx, l, r, lf, s, d);
		if (k != KIND_SPARE && !(k == KIND_NODE && idx == NO_CHILD))
			words_done++;
		@(posedge clk);
	endtask

	task automatic write_node(logic [IDX_W-1:0] idx, logic [IDX_W-1:0] l, logic [IDX_W-1:0] r,
			logic lf, logic [SYM_W-1:0] s);
		send_word(KIND_NODE, idx, l, r, lf, s, SYM_W'($urandom_range(0, 255)));
		if (idx != NO_CHILD && !filled[idx]) begin
			filled[idx] = 1'b1;
			filled_q.push_back(int'(idx));
		end
	endtask

	task automatic send_byte(logic [SYM_W-1:0] d);
		send_word(KIND_DATA, IDX_W'($urandom_range(0, 511)), IDX_W'($urandom_range(0, 511)),
			IDX_W'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
			SYM_W'($urandom_range(0, 255)), d);
	endtask

	task automatic send_restart();
		send_word(KIND_RESTART, IDX_W'($urandom_range(0, 511)), IDX_W'($urandom_range(0, 511)),
			IDX_W'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
			SYM_W'($urandom_range(0, 255)), SYM_W'($urandom_range(0, 255)));
	endtask

	task automatic send_spare();
		send_word(KIND_SPARE, IDX_W'($urandom_range(0, 511)), IDX_W'($urandom_range(0, 511)),
			IDX_W'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
			SYM_W'($urandom_range(0, 255)), SYM_W'($urandom_range(0, 255)));
	endtask

	// children only ever point at written entries, so no walk reads an unwritten one
	function automatic logic [IDX_W-1:0] pick_child();
		if (filled_q.size() == 0 || $urandom_range(0, 5) == 0)
			return NO_CHILD;
		return IDX_W'(filled_q[$urandom_range(0, filled_q.size() - 1)]);
	endfunction

	function automatic logic [IDX_W-1:0] fresh_index();
		int idx;
		do idx = $urandom_range(0, 510); while (in_tree[idx]);
		in_tree[idx] = 1'b1;
		return IDX_W'(idx);
	endfunction

	// build bottom-up: leaves first, then merge subtrees until one root remains
	task automatic grow_tree(output logic [IDX_W-1:0] top);
		int               tops [$];
		int               a;
		int               b;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] l;
		logic [IDX_W-1:0] r;
		in_tree = '{default: 1'b0};
		repeat ($urandom_range(2, 10)) begin
			idx = fresh_index();
			write_node(idx, pick_child(), pick_child(), 1'b1, SYM_W'($urandom_range(0, 255)));
			tops.push_back(int'(idx));
		end
		while (tops.size() > 1) begin
			a = $urandom_range(0, tops.size() - 1);
			l = IDX_W'(tops[a]);
			tops.delete(a);
			b = $urandom_range(0, tops.size() - 1);
			r = IDX_W'(tops[b]);
			tops.delete(b);
			case ($urandom_range(0, 11))
				0: l = NO_CHILD;
				1: r = NO_CHILD;
				default: ;
			endcase
			idx = fresh_index();
			write_node(idx, l, r, 1'b0, SYM_W'($urandom_range(0, 255)));
			tops.push_back(int'(idx));
		end
		top = IDX_W'(tops[0]);
	endtask

	task automatic set_reg(logic [1:0] idx, logic [CNT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(negedge clk); while (!cfg_ready);
		sb.note_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic program_regs(logic [CNT_W-1:0] total, logic [IDX_W-1:0] root, bit spare);
		set_reg(CFG_TOTAL, total);
		set_reg(CFG_ROOT, {{(CNT_W - IDX_W){1'b0}}, root});
		if (spare)
			set_reg(CFG_SPARE, $urandom);
		cfg_valid <= 1'b0;
	endtask

	// hold until every expected word has arrived and the walk has drained
	task automatic settle();
		start <= 1'b0;
		while (sb.expected_syms.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		#5_000_000;
		$display("huffman_tree_walk_decoder regression: fail");
		$finish;
	end

	initial begin
		logic [IDX_W-1:0] top;
		logic [CNT_W-1:0] total;
		int               phase;
		int               sel;
		sb         = new();
		calm       = 1'b0;
		words_done = 0;
		phase      = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		program_regs(32'hFFFF_FFFF, '0, 1'b1);
		write_node(9'd2, NO_CHILD, NO_CHILD, 1'b1, 8'hFF);
		write_node(9'd1, NO_CHILD, NO_CHILD, 1'b1, 8'h00);
		write_node(9'd4, 9'd2, NO_CHILD, 1'b0, 8'h5A);
		write_node(9'd0, 9'd1, 9'd4, 1'b0, 8'h00);
		write_node(NO_CHILD, 9'd0, 9'd0, 1'b1, 8'hFF);
		send_spare();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h4B);
		send_byte(8'h80);
		write_node(9'd1, 9'd2, 9'd1, 1'b1, 8'h00);
		write_node(9'd510, 9'd0, 9'd1, 1'b1, 8'hA5);
		send_restart();
		settle();
		// new root takes effect only at the next return to it
		program_regs(32'd3, 9'd1, 1'b0);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_restart();
		send_byte(8'h5C);
		settle();
		program_regs('0, NO_CHILD, 1'b0);
		send_restart();
		send_byte(8'hFF);
		settle();
		program_regs(32'd5, NO_CHILD, 1'b0);
		send_restart();
		send_byte(8'hA5);
		settle();
		program_regs(32'hFFFF_FFFF, 9'd510, 1'b0);
		send_restart();
		send_byte(8'h3C);

		while (words_done < TARGET_WORDS) begin
			phase++;
			calm = (phase == 3 || phase == 4);
			grow_tree(top);
			settle();
			case ($urandom_range(0, 5))
				0: total = 32'hFFFF_FFFF;
				1: total = '0;
				2: total = $urandom;
				default: total = $urandom_range(1, 30);
			endcase
			if ($urandom_range(0, 11) == 0)
				top = NO_CHILD;
			program_regs(total, top, $urandom_range(0, 7) == 0);
			if ($urandom_range(0, 2) != 0)
				send_restart();
			repeat ($urandom_range(6, 24)) begin
				sel = $urandom_range(0, 99);
				if (sel < 6)
					send_restart();
				else if (sel < 10)
					write_node(($urandom_range(0, 15) == 0) ? NO_CHILD
						: IDX_W'($urandom_range(0, 510)),
						pick_child(), pick_child(), 1'($urandom_range(0, 1)),
						SYM_W'($urandom_range(0, 255)));
				else if (sel < 13)
					send_spare();
				else if (sel < 20)
					send_byte($urandom_range(0, 1) ? 8'hFF : 8'h00);
				else
					send_byte(SYM_W'($urandom_range(0, 255)));
			end
		end

		settle();
		if (sb.mismatches == 0 && sb.expected_syms.size() == 0)
			$display("huffman_tree_walk_decoder regression: pass");
		else
			$display("huffman_tree_walk_decoder regression: fail");
		$finish;
	end
endmodule

>>> files.f
rtl/core/hufd_pkg.sv
rtl/core/hufd_node_ram.sv
rtl/core/hufd_walk.sv
rtl/core/huffman_tree_walk_decoder.sv
bench/tb_top.sv
